FILE: rtl/hpm_pkg.sv
// ---------------------------------------------------------------------------
// hpm_pkg
// Shared types and constants of the homography point mapper.
// ---------------------------------------------------------------------------
package hpm_pkg;

   localparam int COEF_W  = 40;
   localparam int COORD_W = 12;
   localparam int PROD_W  = COEF_W + COORD_W + 1;
   localparam int SUM_W   = PROD_W + 2;
   localparam int MAG_W   = SUM_W;
   localparam int REM_W   = MAG_W + 2 + COORD_W;
   localparam int NUM_REGS = 8;
   localparam int FRAC_BITS = 28;

   typedef enum logic [2:0] {
      REG_M00 = 3'd0,
      REG_M01 = 3'd1,
      REG_M02 = 3'd2,
      REG_M10 = 3'd3,
      REG_M11 = 3'd4,
      REG_M12 = 3'd5,
      REG_M20 = 3'd6,
      REG_M21 = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] m00;
      logic signed [COEF_W-1:0] m01;
      logic signed [COEF_W-1:0] m02;
      logic signed [COEF_W-1:0] m10;
      logic signed [COEF_W-1:0] m11;
      logic signed [COEF_W-1:0] m12;
      logic signed [COEF_W-1:0] m20;
      logic signed [COEF_W-1:0] m21;
   } matrix_type;

   typedef struct packed {
      logic [MAG_W-1:0] ax;
      logic [MAG_W-1:0] ay;
      logic [MAG_W-1:0] bw;
      logic             neg_x;
      logic             neg_y;
      logic             w_zero;
   } job_type;

endpackage

FILE: rtl/homography_point_map.sv
// ---------------------------------------------------------------------------
// homography_point_map
// Maps pixel coordinates through a 3x3 projective matrix (h22 = 1).
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one source point per transaction, rsp_* one mapped point.
//   csr_* writes the eight 40-bit coefficients (Q.28), index = m00..m21.
//   The user writes only while no transaction is in flight; not enforced.
//   Throughput: one point per cycle while rsp is not stalled. The front
//   (three stages: multiply, sum, magnitude/sign) feeds an 8-entry queue;
//   the back divides with one quotient bit per stage over 12 stages plus a
//   setup and an output stage.
//   Reset: coefficients return to the identity map, pipes and queue empty.
//   Stall: a stalled rsp freezes the back; the queue absorbs the front,
//   which stops taking requests once the queue has fewer than four
//   free entries.
// ---------------------------------------------------------------------------
module homography_point_map
   import hpm_pkg::*;
#(
   parameter int WIDTH  = 1280,
   parameter int HEIGHT = 720
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [23:0]       req_tdata,   // point_u[11:0], point_v[23:12]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [23:0]       rsp_tdata,   // mapped_u[11:0], mapped_v[23:12]
   input  logic              csr_we,
   input  logic [2:0]        csr_addr,
   input  logic [COEF_W-1:0] csr_wdata
);

   localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) << FRAC_BITS;
   localparam matrix_type MAT_RESET = '{m00: COEF_ONE, m11: COEF_ONE, default: '0};

   matrix_type         mat_ff;
   logic               fe, push, pop, not_empty, has_room;
   job_type            job, head;
   logic [COORD_W-1:0] mu, mv;

   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff <= MAT_RESET;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_addr))
            REG_M00: mat_ff.m00 <= csr_wdata;
            REG_M01: mat_ff.m01 <= csr_wdata;
            REG_M02: mat_ff.m02 <= csr_wdata;
            REG_M10: mat_ff.m10 <= csr_wdata;
            REG_M11: mat_ff.m11 <= csr_wdata;
            REG_M12: mat_ff.m12 <= csr_wdata;
            REG_M20: mat_ff.m20 <= csr_wdata;
            REG_M21: mat_ff.m21 <= csr_wdata;
            default: mat_ff <= mat_ff;
         endcase
      end
   end

   assign fe         = has_room;
   assign req_tready = fe;

   hpm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .mat      (mat_ff),
      .enable   (fe),
      .in_valid (req_tvalid),
      .in_u     (req_tdata[11:0]),
      .in_v     (req_tdata[23:12]),
      .push     (push),
      .job      (job)
   );

   hpm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (job),
      .pop       (pop),
      .not_empty (not_empty),
      .has_room  (has_room),
      .head      (head)
   );

   hpm_back #(
      .WIDTH  (WIDTH),
      .HEIGHT (HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (not_empty),
      .head      (head),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_u     (mu),
      .out_v     (mv)
   );

   assign rsp_tdata = {mv, mu};

endmodule

FILE: rtl/hpm_front.sv
// ---------------------------------------------------------------------------
// hpm_front
// Accepts coordinates, forms x, y, w and splits them into magnitudes/signs.
// ---------------------------------------------------------------------------
module hpm_front
   import hpm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  matrix_type         mat,
   input  logic               enable,
   input  logic               in_valid,
   input  logic [COORD_W-1:0] in_u,
   input  logic [COORD_W-1:0] in_v,
   output logic               push,
   output job_type            job
);

   logic                     v1_ff, v2_ff, v3_ff;
   logic signed [PROD_W-1:0] p00_ff, p01_ff, p10_ff, p11_ff, p20_ff, p21_ff;
   logic signed [COEF_W-1:0] m02_ff, m12_ff;
   logic signed [SUM_W-1:0]  x_ff, y_ff, w_ff;
   job_type                  job_ff, job_in;
   logic signed [COORD_W:0]  su, sv;

   assign su = $signed({1'b0, in_u});
   assign sv = $signed({1'b0, in_v});

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p00_ff <= PROD_W'(mat.m00) * PROD_W'(su);
         p01_ff <= PROD_W'(mat.m01) * PROD_W'(sv);
         p10_ff <= PROD_W'(mat.m10) * PROD_W'(su);
         p11_ff <= PROD_W'(mat.m11) * PROD_W'(sv);
         p20_ff <= PROD_W'(mat.m20) * PROD_W'(su);
         p21_ff <= PROD_W'(mat.m21) * PROD_W'(sv);
         m02_ff <= mat.m02;
         m12_ff <= mat.m12;
         x_ff   <= SUM_W'(p00_ff) + SUM_W'(p01_ff) + SUM_W'(m02_ff);
         y_ff   <= SUM_W'(p10_ff) + SUM_W'(p11_ff) + SUM_W'(m12_ff);
         w_ff   <= SUM_W'(p20_ff) + SUM_W'(p21_ff) + (SUM_W'(1) << FRAC_BITS);
         job_ff <= job_in;
      end
   end

   always_comb begin
      job_in.ax     = x_ff[SUM_W-1] ? MAG_W'(-x_ff) : MAG_W'(x_ff);
      job_in.ay     = y_ff[SUM_W-1] ? MAG_W'(-y_ff) : MAG_W'(y_ff);
      job_in.bw     = w_ff[SUM_W-1] ? MAG_W'(-w_ff) : MAG_W'(w_ff);
      job_in.neg_x  = x_ff[SUM_W-1] ^ w_ff[SUM_W-1];
      job_in.neg_y  = y_ff[SUM_W-1] ^ w_ff[SUM_W-1];
      job_in.w_zero = (w_ff == '0);
   end

   assign push = v3_ff && enable;
   assign job  = job_ff;

endmodule

FILE: rtl/hpm_queue.sv
// ---------------------------------------------------------------------------
// hpm_queue
// Short first-word-fall-through queue between front and back.
// ---------------------------------------------------------------------------
module hpm_queue
   import hpm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    not_empty,
   output logic    has_room,
   output job_type head
);

   localparam int DEPTH = 8;
   localparam int AW    = $clog2(DEPTH);

   job_type       mem [0:DEPTH-1];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [AW:0]   cnt_ff, cnt_in;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_job;
      end
   end

   assign head      = mem[rd_ff];
   assign not_empty = (cnt_ff != '0);
   assign has_room  = (cnt_ff <= (AW+1)'(DEPTH - 4));

endmodule

FILE: rtl/hpm_back.sv
// ---------------------------------------------------------------------------
// hpm_back
// Rounded division pipeline (one quotient bit per stage) and clamp.
// ---------------------------------------------------------------------------
module hpm_back
   import hpm_pkg::*;
#(
   parameter int WIDTH  = 1280,
   parameter int HEIGHT = 720
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               not_empty,
   input  job_type            head,
   output logic               pop,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [COORD_W-1:0] out_u,
   output logic [COORD_W-1:0] out_v
);

   localparam int NST = COORD_W;
   localparam logic [COORD_W-1:0] LIM_U = COORD_W'(WIDTH - 1);
   localparam logic [COORD_W-1:0] LIM_V = COORD_W'(HEIGHT - 1);

   logic               be;
   logic               vld_ff  [0:NST];
   logic [REM_W-1:0]   rx_ff   [0:NST];
   logic [REM_W-1:0]   ry_ff   [0:NST];
   logic [REM_W-1:0]   d_ff    [0:NST];
   logic [COORD_W-1:0] qx_ff   [0:NST];
   logic [COORD_W-1:0] qy_ff   [0:NST];
   logic               zx_ff   [0:NST];
   logic               zy_ff   [0:NST];
   logic               ox_ff   [0:NST];
   logic               oy_ff   [0:NST];
   logic               ovld_ff;
   logic [COORD_W-1:0] ou_ff, ov_ff;
   logic [REM_W-1:0]   nx, ny, dd;
   logic [COORD_W-1:0] ru, rv;

   assign be  = !ovld_ff || out_ready;
   assign pop = be && not_empty;

   assign nx = (REM_W'(head.ax) << 1) + REM_W'(head.bw);
   assign ny = (REM_W'(head.ay) << 1) + REM_W'(head.bw);
   assign dd = REM_W'(head.bw) << 1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (be) begin
         vld_ff[0] <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (be) begin
         rx_ff[0] <= nx;
         ry_ff[0] <= ny;
         d_ff[0]  <= dd;
         qx_ff[0] <= '0;
         qy_ff[0] <= '0;
         zx_ff[0] <= head.w_zero || head.neg_x;
         zy_ff[0] <= head.w_zero || head.neg_y;
         ox_ff[0] <= nx >= (dd << NST);
         oy_ff[0] <= ny >= (dd << NST);
      end
   end

   for (genvar k = 0; k < NST; k++) begin : g_div
      localparam int SH = NST - 1 - k;
      logic [REM_W-1:0]   ds;
      logic               tx, ty;
      logic [COORD_W-1:0] qxn, qyn;
      assign ds  = d_ff[k] << SH;
      assign tx  = rx_ff[k] >= ds;
      assign ty  = ry_ff[k] >= ds;
      assign qxn = qx_ff[k] | (COORD_W'(tx) << SH);
      assign qyn = qy_ff[k] | (COORD_W'(ty) << SH);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (be) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (be) begin
            rx_ff[k+1] <= tx ? rx_ff[k] - ds : rx_ff[k];
            ry_ff[k+1] <= ty ? ry_ff[k] - ds : ry_ff[k];
            d_ff[k+1]  <= d_ff[k];
            qx_ff[k+1] <= qxn;
            qy_ff[k+1] <= qyn;
            zx_ff[k+1] <= zx_ff[k];
            zy_ff[k+1] <= zy_ff[k];
            ox_ff[k+1] <= ox_ff[k];
            oy_ff[k+1] <= oy_ff[k];
         end
      end
   end

   always_comb begin
      priority if (zx_ff[NST]) begin
         ru = '0;
      end else if (ox_ff[NST] || qx_ff[NST] > LIM_U) begin
         ru = LIM_U;
      end else begin
         ru = qx_ff[NST];
      end
      priority if (zy_ff[NST]) begin
         rv = '0;
      end else if (oy_ff[NST] || qy_ff[NST] > LIM_V) begin
         rv = LIM_V;
      end else begin
         rv = qy_ff[NST];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovld_ff <= 1'b0;
      end else if (be) begin
         ovld_ff <= vld_ff[NST];
      end
   end

   always_ff @(posedge clock) begin
      if (be) begin
         ou_ff <= ru;
         ov_ff <= rv;
      end
   end

   assign out_valid = ovld_ff;
   assign out_u     = ou_ff;
   assign out_v     = ov_ff;

endmodule

FILE: dv/homography_point_map_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// homography_point_map_tb
// Drives source points through the projective point mapper under several
// coefficient sets and checks every mapped point against a built-in
// fixed-point predictor.
// ---------------------------------------------------------------------------
module homography_point_map_tb;
   import hpm_pkg::*;

   localparam int IMG_W      = 1280;
   localparam int IMG_H      = 720;
   localparam int LAT        = 18;
   localparam int MAX_CYCLES = 400000;
   localparam logic signed [COEF_W-1:0] ONE = 40'sd1 << FRAC_BITS;
   localparam logic signed [COEF_W-1:0] CMAX = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic signed [COEF_W-1:0] CMIN = {1'b1, {(COEF_W-1){1'b0}}};
   localparam longint LONE = 64'sd1 << FRAC_BITS;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [23:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [2:0] csr_addr = '0;
   logic [COEF_W-1:0] csr_wdata = '0;

   matrix_type coef;
   logic [23:0] mapped_q[$];
   int errors = 0;
   int points_sent = 0;
   int points_seen = 0;
   int cycles = 0;
   int src_idle = 0;
   int snk_idle = 0;
   bit saw_zero_w = 0;

   homography_point_map #(.WIDTH(IMG_W), .HEIGHT(IMG_H)) i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic [11:0] round_clamp(longint num, longint den, int limit);
      longint a, b, q;
      bit neg;
      neg = (num < 0) != (den < 0);
      a = (num < 0) ? -num : num;
      b = (den < 0) ? -den : den;
      q = (2 * a + b) / (2 * b);
      if (neg && q != 0) return 12'd0;
      if (q > limit) return 12'(limit);
      return 12'(q);
   endfunction

   function automatic logic [23:0] map_point(logic [11:0] u, logic [11:0] v);
      longint x, y, w, lu, lv;
      lu = longint'(u);
      lv = longint'(v);
      x = longint'(coef.m00) * lu + longint'(coef.m01) * lv + longint'(coef.m02);
      y = longint'(coef.m10) * lu + longint'(coef.m11) * lv + longint'(coef.m12);
      w = longint'(coef.m20) * lu + longint'(coef.m21) * lv + longint'(ONE);
      if (w == 0) begin
         saw_zero_w = 1;
         return 24'd0;
      end
      return {round_clamp(y, w, IMG_H - 1), round_clamp(x, w, IMG_W - 1)};
   endfunction

   task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] exp);
      errors++;
      $display("mismatch %s: got u=%0d v=%0d exp u=%0d v=%0d", what,
               got[11:0], got[23:12], exp[11:0], exp[23:12]);
   endtask

   // response side: random backpressure, compare in order
   always @(negedge clock) begin
      if (!reset) rsp_tready <= ($urandom_range(99) >= snk_idle);
   end

   always @(posedge clock) begin
      logic [23:0] exp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         points_seen++;
         if (mapped_q.size() == 0) begin
            report_mismatch("unexpected", rsp_tdata, 24'd0);
         end else begin
            exp = mapped_q.pop_front();
            if (rsp_tdata[11:0] !== exp[11:0]) report_mismatch("mapped_u", rsp_tdata, exp);
            else if (rsp_tdata[23:12] !== exp[23:12])
               report_mismatch("mapped_v", rsp_tdata, exp);
         end
      end
   end

   // valid stays high between back-to-back transactions; drain() drops it
   task automatic send_point(logic [11:0] u, logic [11:0] v);
      while ($urandom_range(99) < src_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {v, u};
      mapped_q.push_back(map_point(u, v));
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      points_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (mapped_q.size() != 0) @(negedge clock);
      repeat (LAT + 4) @(negedge clock);
   endtask

   task automatic write_coef(reg_index_type idx, logic signed [COEF_W-1:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(negedge clock);
      case (idx)
         REG_M00: coef.m00 = val;
         REG_M01: coef.m01 = val;
         REG_M02: coef.m02 = val;
         REG_M10: coef.m10 = val;
         REG_M11: coef.m11 = val;
         REG_M12: coef.m12 = val;
         REG_M20: coef.m20 = val;
         default: coef.m21 = val;
      endcase
   endtask

   task automatic load_matrix(logic signed [COEF_W-1:0] a, b, c, d, e, f, g, h);
      drain();
      write_coef(REG_M00, a);
      write_coef(REG_M01, b);
      write_coef(REG_M02, c);
      write_coef(REG_M10, d);
      write_coef(REG_M11, e);
      write_coef(REG_M12, f);
      write_coef(REG_M20, g);
      write_coef(REG_M21, h);
      csr_we <= 1'b0;
   endtask

   function automatic logic [11:0] rnd_coord();
      case ($urandom_range(5))
         0: return 12'd0;
         1: return 12'hFFF;
         2: return 12'($urandom_range(IMG_W - 1));
         default: return 12'($urandom);
      endcase
   endfunction

   // small perturbation around a scaled value
   function automatic logic signed [COEF_W-1:0] near(longint base, longint spread);
      longint unsigned r;
      r = {$urandom, $urandom};
      return COEF_W'(base + longint'(r % longint'(2 * spread + 1)) - spread);
   endfunction

   task automatic test_identity();
      send_point(12'd0, 12'd0);
      send_point(12'hFFF, 12'hFFF);
      send_point(12'd1279, 12'd719);
      send_point(12'd1280, 12'd720);
      send_point(12'hAAA, 12'h555);
      send_point(12'h555, 12'hAAA);
   endtask

   task automatic test_special_cases();
      // half scale: exact .5 ties round away from zero
      load_matrix(ONE >>> 1, 0, 0, 0, ONE >>> 1, 0, 0, 0);
      send_point(12'd1, 12'd3);
      send_point(12'd5, 12'd7);
      // negative scale and offset: negative results clamp to zero
      load_matrix(-ONE, 0, -(ONE >>> 1), 0, -ONE, ONE >>> 1, 0, 0);
      send_point(12'd0, 12'd0);
      send_point(12'd100, 12'd200);
      // w = 1 - u/16 becomes zero at u = 16, negative beyond
      load_matrix(ONE, 0, 0, 0, ONE, 0, -(ONE >>> 4), 0);
      send_point(12'd16, 12'd5);
      send_point(12'd8, 12'd3);
      send_point(12'd40, 12'd30);
      load_matrix(ONE, 0, 0, 0, ONE, 0, 0, -(ONE >>> 3));
      send_point(12'd9, 12'd8);
      // coefficient extremes
      load_matrix(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN);
      send_point(12'hFFF, 12'hFFF);
      send_point(12'hFFF, 12'd0);
      send_point(12'd0, 12'hFFF);
      send_point(12'd1, 12'd1);
      load_matrix(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX);
      send_point(12'hFFF, 12'hFFF);
      send_point(12'd0, 12'd0);
      send_point(12'd7, 12'd3);
   endtask

   task automatic test_random_matrices(int rounds, int per_round);
      for (int r = 0; r < rounds; r++) begin
         case ($urandom_range(3))
            0: load_matrix(near(ONE, 1 << 26), near(0, 1 << 25), near(0, 64 * LONE),
                           near(0, 1 << 25), near(ONE, 1 << 26), near(0, 64 * LONE),
                           near(0, 1 << 16), near(0, 1 << 16));
            1: load_matrix(COEF_W'({$urandom, $urandom}), COEF_W'({$urandom, $urandom}),
                           COEF_W'({$urandom, $urandom}), COEF_W'({$urandom, $urandom}),
                           COEF_W'({$urandom, $urandom}), COEF_W'({$urandom, $urandom}),
                           COEF_W'({$urandom, $urandom}), COEF_W'({$urandom, $urandom}));
            2: load_matrix(near(0, 4 * LONE), near(0, 4 * LONE), near(0, 2000 * LONE),
                           near(0, 4 * LONE), near(0, 4 * LONE), near(0, 2000 * LONE),
                           near(0, 1 << 19), near(0, 1 << 19));
            default: load_matrix(near(ONE, 1 << 20), 0, near(0, LONE), 0,
                                 near(ONE, 1 << 20), near(0, LONE),
                                 -(ONE >>> $urandom_range(4, 12)), 0);
         endcase
         for (int i = 0; i < per_round; i++) send_point(rnd_coord(), rnd_coord());
      end
   endtask

   initial begin
      coef = '{m00: ONE, m11: ONE, default: '0};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      src_idle = 18; snk_idle = 79;
      test_identity();
      test_special_cases();
      test_random_matrices(15, 30);
      src_idle = 79; snk_idle = 18;
      test_random_matrices(15, 30);
      src_idle = 0; snk_idle = 0;
      test_random_matrices(15, 30);
      drain();
      $display("mapped %0d points (%0d checked) across identity, tie, clamp and random matrices",
               points_sent, points_seen);
      $display("zero denominator reached: %0d", saw_zero_w);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", errors);
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
